>>> src/digital_input_snapshot_debounce_top_assert.svh
// Assertion macros shared by the checker of the debounce block.
`ifndef DIGITAL_INPUT_SNAPSHOT_DEBOUNCE_TOP_ASSERT_SVH
`define DIGITAL_INPUT_SNAPSHOT_DEBOUNCE_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define DSD_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define DSD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> src/dsd_pkg.sv
// Package with constants, types and write-port structs of the debounce block.
`timescale 1ns / 1ps
`default_nettype none
package dsd_pkg;

   localparam int NUM_MODULES = 16;
   localparam int PORT_WIDTH  = 32;

   localparam int MOD_IDX_W = 4;
   localparam int CHAN_W    = 6;
   localparam int WORD_W    = 32;
   localparam int HOLD_W    = 16;
   localparam int TIME_W    = 31;
   localparam int POS_W     = 5;
   localparam int SLOTS     = 32;

   localparam int MOD_AW     = (NUM_MODULES > 1) ? $clog2(NUM_MODULES) : 1;
   localparam int FILT_DEPTH = NUM_MODULES * SLOTS;
   localparam int FILT_AW    = MOD_AW + POS_W;

   localparam logic [WORD_W-1:0] PORT_MASK = WORD_W'((64'd1 << PORT_WIDTH) - 64'd1);

   typedef struct packed {
      logic [WORD_W-1:0] cache;
      logic [WORD_W-1:0] mask;
   } mod_entry_type;

   typedef struct packed {
      logic              accepted_bit;
      logic [TIME_W-1:0] start;
   } filt_entry_type;

   typedef struct packed {
      logic              en;
      logic [MOD_AW-1:0] addr;
      mod_entry_type     data;
   } mod_wr_type;

   typedef struct packed {
      logic               en;
      logic [FILT_AW-1:0] addr;
      filt_entry_type     data;
   } filt_wr_type;

   typedef struct packed {
      logic [MOD_IDX_W-1:0] module_index;
      logic [CHAN_W-1:0]    channel_number;
      logic [WORD_W-1:0]    port_word;
      logic [HOLD_W-1:0]    hold_time;
      logic [TIME_W-1:0]    now_time;
   } req_type;

   typedef struct packed {
      logic [WORD_W-1:0] read_value;
      logic              change_pending;
   } rsp_type;

endpackage
`default_nettype wire

>>> src/dsd_req_if.sv
// Request channel interface: valid, ready and the access fields.
`timescale 1ns / 1ps
`default_nettype none
interface dsd_req_if import dsd_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [MOD_IDX_W-1:0] module_index;
   logic [CHAN_W-1:0]    channel_number;
   logic [WORD_W-1:0]    port_word;
   logic [HOLD_W-1:0]    hold_time;
   logic [TIME_W-1:0]    now_time;

   modport source (output valid, module_index, channel_number, port_word, hold_time,
                   now_time, input ready);
   modport sink   (input valid, module_index, channel_number, port_word, hold_time,
                   now_time, output ready);
endinterface
`default_nettype wire

>>> src/dsd_rsp_if.sv
// Response channel interface: valid, ready and the result fields.
`timescale 1ns / 1ps
`default_nettype none
interface dsd_rsp_if import dsd_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [WORD_W-1:0] read_value;
   logic              change_pending;

   modport source (output valid, read_value, change_pending, input ready);
   modport sink   (input valid, read_value, change_pending, output ready);
endinterface
`default_nettype wire

>>> src/dsd_mod_store.sv
// Per-module memory of cached port word and unread mask, with entry valid bits.
`timescale 1ns / 1ps
`default_nettype none
module dsd_mod_store import dsd_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              rd_en,
   input  wire logic [MOD_AW-1:0] rd_addr,
   input  wire mod_wr_type        wr,
   output mod_entry_type          rd_data
);

   mod_entry_type              store_mem [NUM_MODULES];
   mod_entry_type              rd_data_ff;
   logic                       rd_valid_ff;
   logic [NUM_MODULES-1:0]     valid_ff;
   logic                       wr_hit;

   // A write at the same edge as the read is passed straight to the read register.
   assign wr_hit = wr.en && (wr.addr == rd_addr);

   always_ff @(posedge clock) begin
      if (wr.en) begin
         store_mem[wr.addr] <= wr.data;
      end
      if (rd_en) begin
         rd_data_ff <= wr_hit ? wr.data : store_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr.en) begin
            valid_ff[wr.addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_valid_ff <= wr_hit || valid_ff[rd_addr];
         end
      end
   end

   // An entry never written has an all-zero unread mask, so its cache is not used.
   assign rd_data.cache = rd_data_ff.cache;
   assign rd_data.mask  = rd_valid_ff ? rd_data_ff.mask : '0;

endmodule
`default_nettype wire

>>> src/dsd_filt_store.sv
// Per-channel filter memory with a clearing sweep after reset.
`timescale 1ns / 1ps
`default_nettype none
module dsd_filt_store import dsd_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               rd_en,
   input  wire logic [FILT_AW-1:0] rd_addr,
   input  wire filt_wr_type        wr,
   output filt_entry_type          rd_data,
   output logic                    clear_busy
);

   filt_entry_type     filt_mem [FILT_DEPTH];
   filt_entry_type     rd_data_ff;
   logic [FILT_AW-1:0] clr_addr_ff;
   logic               clr_busy_ff;
   logic               wr_hit;

   assign wr_hit = wr.en && (wr.addr == rd_addr);

   always_ff @(posedge clock) begin
      if (clr_busy_ff) begin
         filt_mem[clr_addr_ff] <= '0;
      end else if (wr.en) begin
         filt_mem[wr.addr] <= wr.data;
      end
      if (rd_en) begin
         rd_data_ff <= wr_hit ? wr.data : filt_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff <= '0;
         clr_busy_ff <= 1'b1;
      end else if (clr_busy_ff) begin
         if (clr_addr_ff == FILT_AW'(FILT_DEPTH - 1)) begin
            clr_busy_ff <= 1'b0;
         end
         clr_addr_ff <= clr_addr_ff + 1'b1;
      end
   end

   assign rd_data    = rd_data_ff;
   assign clear_busy = clr_busy_ff;

endmodule
`default_nettype wire

>>> src/dsd_update.sv
// Read-modify-write logic: unread mask update, bit select and debounce decision.
`timescale 1ns / 1ps
`default_nettype none
module dsd_update import dsd_pkg::*; (
   input  wire logic           advance,
   input  wire req_type        req,
   input  wire mod_entry_type  mod_entry,
   input  wire filt_entry_type filt_entry,
   output rsp_type             result,
   output mod_wr_type          mod_wr,
   output filt_wr_type         filt_wr
);

   logic              in_range;
   logic [CHAN_W-1:0] ch_m1;
   logic [POS_W-1:0]  pos;
   logic [WORD_W-1:0] sel;
   logic [WORD_W-1:0] word;
   logic [WORD_W-1:0] tmp;
   logic              raw_bit;
   logic              prev_bit;
   logic [TIME_W-1:0] start;
   logic [TIME_W-1:0] elapsed;
   logic              held_long;
   logic [MOD_AW-1:0] mod_idx;

   always_comb begin
      in_range  = (32'(req.module_index) < 32'(NUM_MODULES))
               && (req.channel_number <= CHAN_W'(PORT_WIDTH));
      ch_m1     = req.channel_number - CHAN_W'(1);
      pos       = ch_m1[POS_W-1:0];
      sel       = WORD_W'(1) << pos;
      word      = req.port_word & PORT_MASK;
      mod_idx   = MOD_AW'(req.module_index);
      prev_bit  = filt_entry.accepted_bit;
      // A stored start of zero means no timer is running; it starts now.
      start     = (filt_entry.start == '0) ? req.now_time : filt_entry.start;
      elapsed   = req.now_time - start;
      held_long = elapsed >= TIME_W'(req.hold_time);

      tmp     = word;
      raw_bit = 1'b0;
      result  = '0;
      mod_wr  = '0;
      filt_wr = '0;
      mod_wr.addr  = mod_idx;
      filt_wr.addr = {mod_idx, pos};

      if (in_range) begin
         mod_wr.en = advance;
         if (req.channel_number == '0) begin
            mod_wr.data.cache = word;
            mod_wr.data.mask  = PORT_MASK;
            result.read_value = word;
         end else begin
            if ((mod_entry.mask & sel) != '0) begin
               tmp               = mod_entry.cache;
               mod_wr.data.cache = mod_entry.cache;
               mod_wr.data.mask  = mod_entry.mask & ~sel;
            end else begin
               mod_wr.data.cache = word;
               mod_wr.data.mask  = PORT_MASK & ~sel;
            end
            raw_bit = tmp[pos];
            result.read_value = WORD_W'(raw_bit);
            if (req.hold_time != '0) begin
               filt_wr.en = advance;
               if (prev_bit == raw_bit) begin
                  filt_wr.data = {prev_bit, TIME_W'(0)};
               end else if (held_long) begin
                  filt_wr.data = {raw_bit, TIME_W'(0)};
               end else begin
                  filt_wr.data          = {prev_bit, start};
                  result.read_value     = WORD_W'(prev_bit);
                  result.change_pending = 1'b1;
               end
            end
         end
      end
   end

endmodule
`default_nettype wire

>>> src/digital_input_snapshot_debounce_top.sv
// An accepted request waits in stage 1 for both memory reads; its response then enters
// the output register, which holds it until the sink takes it. Throughput: one request
// per cycle while the output is not stalled, set by the registered read of both
// memories and a single write back per cycle with same-edge bypass into the read
// registers. Reset: synchronous; module valid bits clear at once, then the filter
// memory's NUM_MODULES*32 (512) entries are swept to zero, request side not ready.
`timescale 1ns / 1ps
`default_nettype none
module digital_input_snapshot_debounce_top import dsd_pkg::*; (
   input wire logic clock,
   input wire logic reset,
   dsd_req_if.sink  req_chan,
   dsd_rsp_if.source rsp_chan
);

   // Stage 1 holds the accepted request while its memory reads come back.
   logic           s1_valid_ff;
   req_type        s1_req_ff;
   // The output register keeps the finished response until the sink takes it.
   logic           rsp_valid_ff;
   rsp_type        rsp_data_ff;

   logic           req_fire;
   logic           advance;
   logic           clear_busy;
   req_type        req_in;
   logic [CHAN_W-1:0] rd_ch_m1;
   logic [MOD_AW-1:0] rd_mod;
   mod_entry_type  mod_entry;
   filt_entry_type filt_entry;
   mod_wr_type     mod_wr;
   filt_wr_type    filt_wr;
   rsp_type        result;

   assign req_in.module_index   = req_chan.module_index;
   assign req_in.channel_number = req_chan.channel_number;
   assign req_in.port_word      = req_chan.port_word;
   assign req_in.hold_time      = req_chan.hold_time;
   assign req_in.now_time       = req_chan.now_time;

   // Stage 1 moves on when the output register is empty or is being drained.
   assign advance        = s1_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !clear_busy && (!s1_valid_ff || advance);
   assign req_fire       = req_chan.valid && req_chan.ready;

   // Memory addresses come straight from the request so that data arrives in stage 1.
   assign rd_ch_m1 = req_chan.channel_number - CHAN_W'(1);
   assign rd_mod   = MOD_AW'(req_chan.module_index);

   dsd_mod_store u_mod_store (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (req_fire),
      .rd_addr (rd_mod),
      .wr      (mod_wr),
      .rd_data (mod_entry)
   );

   dsd_filt_store u_filt_store (
      .clock      (clock),
      .reset      (reset),
      .rd_en      (req_fire),
      .rd_addr    ({rd_mod, rd_ch_m1[POS_W-1:0]}),
      .wr         (filt_wr),
      .rd_data    (filt_entry),
      .clear_busy (clear_busy)
   );

   // The update writes back in the same cycle the response enters the output register;
   // a request read at that edge receives the written entry through the bypass.
   dsd_update u_update (
      .advance    (advance),
      .req        (s1_req_ff),
      .mod_entry  (mod_entry),
      .filt_entry (filt_entry),
      .result     (result),
      .mod_wr     (mod_wr),
      .filt_wr    (filt_wr)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_chan.ready) begin
            s1_valid_ff <= req_chan.valid;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_req_ff <= req_in;
      end
      if (advance) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.read_value     = rsp_data_ff.read_value;
   assign rsp_chan.change_pending = rsp_data_ff.change_pending;

endmodule
`default_nettype wire

>>> src/dsd_checker.sv
// Port-level checker for the debounce block, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "digital_input_snapshot_debounce_top_assert.svh"
module dsd_checker import dsd_pkg::*; (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_valid,
   input wire logic              req_ready,
   input wire logic              rsp_valid,
   input wire logic              rsp_ready,
   input wire logic [WORD_W-1:0] rsp_read_value,
   input wire logic              rsp_change_pending
);

   // A stalled response keeps its payload.
   `DSD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_read_value) && $stable(rsp_change_pending), "response changed while stalled")

   // The filter memory sweep keeps requests out right after reset.
   `DSD_ASSERT_SAME(a_clear_after_reset, clock, reset, $past(reset), !req_ready, "request side ready during clearing sweep")

   // A pending change always reports a single bit.
   `DSD_ASSERT_SAME(a_pending_bit, clock, reset, rsp_valid && rsp_change_pending, rsp_read_value[WORD_W-1:1] == '0, "pending response carries more than one bit")

   // A response appearing on an idle output must follow an accepted request.
   `DSD_ASSERT_SAME(a_rsp_origin, clock, reset, $rose(rsp_valid), $past(req_valid && req_ready, 2), "response without a matching request")

endmodule

bind digital_input_snapshot_debounce_top dsd_checker u_dsd_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_chan.valid),
   .req_ready          (req_chan.ready),
   .rsp_valid          (rsp_chan.valid),
   .rsp_ready          (rsp_chan.ready),
   .rsp_read_value     (rsp_chan.read_value),
   .rsp_change_pending (rsp_chan.change_pending)
);
`default_nettype wire
